[rtl/ppr_pkg.sv]
// Shared types and constants for the pump PWM ramp block.
// Used by ppr_chan and pump_pwm_ramp_with_watchdog; depends on nothing.
`default_nettype none

package ppr_pkg;

    localparam int PWM_W      = 8;
    localparam int FRAC_W     = 17;
    localparam int STEP_CNT_W = 10;
    localparam int WD_CNT_W   = 13;
    localparam int LED_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = PWM_W + FRAC_W - 1;

    localparam int S_TDATA_W = ((2 * FRAC_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * PWM_W + 1 + 7) / 8) * 8;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

    localparam logic [STEP_CNT_W-1:0] STEP_CNT_MAX = '1;
    localparam logic [WD_CNT_W-1:0]   WD_CNT_MAX   = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_HOLD    = 3'd5;

    // input kinds carried in s_tuser
    localparam logic CMD_SETPOINT = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [PWM_W-1:0]      RST_PWM_LOW     = 8'd128;
    localparam logic [PWM_W-1:0]      RST_PWM_HIGH    = 8'd250;
    localparam logic [PWM_W-1:0]      RST_STEP_LIMIT  = 8'd5;
    localparam logic [STEP_CNT_W-1:0] RST_RAMP_PERIOD = 10'd100;
    localparam logic [WD_CNT_W-1:0]   RST_WATCHDOG    = 13'd4000;
    localparam logic [LED_W-1:0]      RST_LED_HOLD    = 11'd1000;
    localparam logic [PWM_W-1:0]      RST_STOP        = PWM_W'((128 + 250) / 2);

    typedef struct packed {
        logic [PWM_W-1:0]      pwm_low;
        logic [PWM_W-1:0]      pwm_high;
        logic [PWM_W-1:0]      step_limit;
        logic [STEP_CNT_W-1:0] ramp_period;
        logic [WD_CNT_W-1:0]   watchdog;
        logic [LED_W-1:0]      led_hold;
    } cfg_t;

    // per-item control shared by both channels
    typedef struct packed {
        logic             is_cmd;
        logic             snap;
        logic             step;
        logic [PWM_W-1:0] stop_val;
    } chan_ctl_t;

endpackage

`default_nettype wire

[rtl/ppr_chan.sv]
// One pump channel: fraction-to-duty mapping, watchdog snap, ramp step, clamp.
// Purely combinational; depends on ppr_pkg.
`default_nettype none

module ppr_chan import ppr_pkg::*; (
    input  cfg_t                cfg,
    input  chan_ctl_t           ctl,
    input  logic [FRAC_W-1:0]   frac,
    input  logic [PWM_W-1:0]    target_q,
    input  logic [PWM_W-1:0]    drive_q,
    output logic [PWM_W-1:0]    target_cmd,
    output logic [PWM_W-1:0]    target_tick,
    output logic [PWM_W-1:0]    drive_d,
    output logic [PWM_W-1:0]    pwm
);

    logic [FRAC_W-1:0] frac_sat;
    logic              hi_ge_lo;
    logic [PWM_W-1:0]  span;
    logic [PROD_W-1:0] prod;
    logic [PWM_W-1:0]  offs;
    logic [PWM_W-1:0]  d_snap;
    logic [PWM_W-1:0]  diff;
    logic [PWM_W-1:0]  move;
    logic [PWM_W-1:0]  ramped;
    logic              up;

    assign frac_sat = (frac > FRAC_ONE) ? FRAC_ONE : frac;
    assign hi_ge_lo = cfg.pwm_high >= cfg.pwm_low;
    assign span     = hi_ge_lo ? (cfg.pwm_high - cfg.pwm_low) : (cfg.pwm_low - cfg.pwm_high);
    assign prod     = PROD_W'(span) * PROD_W'(frac_sat);
    assign offs     = prod[PROD_W-1:FRAC_W-1];

    // negative span maps downward from pwm_low
    assign target_cmd = hi_ge_lo ? (cfg.pwm_low + offs) : (cfg.pwm_low - offs);

    assign target_tick = ctl.snap ? ctl.stop_val : target_q;
    assign d_snap      = ctl.snap ? ctl.stop_val : drive_q;

    assign up     = target_tick >= d_snap;
    assign diff   = up ? (target_tick - d_snap) : (d_snap - target_tick);
    assign move   = (diff > cfg.step_limit) ? cfg.step_limit : diff;
    assign ramped = up ? (d_snap + move) : (d_snap - move);

    always_comb begin
        if (ctl.is_cmd) begin
            drive_d = drive_q;
        end else if (ctl.step) begin
            drive_d = ramped;
        end else begin
            drive_d = d_snap;
        end
    end

    // upper bound is tested first
    always_comb begin
        if (drive_d > cfg.pwm_high) begin
            pwm = cfg.pwm_high;
        end else if (drive_d < cfg.pwm_low) begin
            pwm = cfg.pwm_low;
        end else begin
            pwm = drive_d;
        end
    end

endmodule

`default_nettype wire

[rtl/pump_pwm_ramp_with_watchdog.sv]
// Top level of the two-channel pump PWM ramp with communication watchdog.
// Depends on ppr_pkg and ppr_chan.
//
// Each request is either a setpoint command (s_tuser = 0, two Q1.16 demand
// fractions in s_tdata) or one elapsed millisecond (s_tuser = 1). Every request
// yields exactly one result with both clamped duties and the sync LED state.
// A request is held in an input register and is processed from there into the
// result register once the result slot is free or is being taken, and a new
// request is taken every clock while the result side keeps up; the input
// register takes one more request while a result waits. Configuration
// registers are written through cfg_wr_en/cfg_index/cfg_wdata and should only
// change while no request is in flight.
`default_nettype none

module pump_pwm_ramp_with_watchdog import ppr_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,    // pump_a_fraction[16:0], pump_b_fraction[33:17]
    input  logic                    s_tuser,    // cmd
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,    // pwm_a[7:0], pwm_b[15:8], sync_led[16]
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic                  in_cmd_reg;
    logic [FRAC_W-1:0]     in_frac_a_reg;
    logic [FRAC_W-1:0]     in_frac_b_reg;
    logic [PWM_W-1:0]      target_a_reg, target_a_next;
    logic [PWM_W-1:0]      target_b_reg, target_b_next;
    logic [PWM_W-1:0]      drive_a_reg, drive_a_next;
    logic [PWM_W-1:0]      drive_b_reg, drive_b_next;
    logic [WD_CNT_W-1:0]   since_cmd_reg, since_cmd_next;
    logic [STEP_CNT_W-1:0] since_step_reg, since_step_next;
    logic [LED_W-1:0]      led_reg, led_next;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;

    logic                  s_fire;
    logic                  fire;
    logic                  is_cmd;
    logic [WD_CNT_W-1:0]   since_cmd_inc;
    logic [STEP_CNT_W-1:0] since_step_inc;
    logic [PWM_W:0]        stop_sum;
    chan_ctl_t             ctl;
    logic [PWM_W-1:0]      tgt_cmd_a, tgt_cmd_b, tgt_tick_a, tgt_tick_b;
    logic [PWM_W-1:0]      pwm_a, pwm_b;
    logic                  changed;

    // advance the held request when the result slot is free or being taken
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign is_cmd         = in_cmd_reg == CMD_SETPOINT;
    assign since_cmd_inc  = (since_cmd_reg == WD_CNT_MAX) ? since_cmd_reg : since_cmd_reg + 1'b1;
    assign since_step_inc = (since_step_reg == STEP_CNT_MAX) ?
                            since_step_reg : since_step_reg + 1'b1;
    assign stop_sum       = {1'b0, cfg_reg.pwm_low} + {1'b0, cfg_reg.pwm_high};

    assign ctl.is_cmd   = is_cmd;
    assign ctl.snap     = since_cmd_inc >= cfg_reg.watchdog;
    assign ctl.step     = since_step_inc >= cfg_reg.ramp_period;
    assign ctl.stop_val = stop_sum[PWM_W:1];

    ppr_chan u_chan_a (
        .cfg         (cfg_reg),
        .ctl         (ctl),
        .frac        (in_frac_a_reg),
        .target_q    (target_a_reg),
        .drive_q     (drive_a_reg),
        .target_cmd  (tgt_cmd_a),
        .target_tick (tgt_tick_a),
        .drive_d     (drive_a_next),
        .pwm         (pwm_a)
    );

    ppr_chan u_chan_b (
        .cfg         (cfg_reg),
        .ctl         (ctl),
        .frac        (in_frac_b_reg),
        .target_q    (target_b_reg),
        .drive_q     (drive_b_reg),
        .target_cmd  (tgt_cmd_b),
        .target_tick (tgt_tick_b),
        .drive_d     (drive_b_next),
        .pwm         (pwm_b)
    );

    assign changed = (tgt_cmd_a != target_a_reg) || (tgt_cmd_b != target_b_reg);

    always_comb begin
        if (is_cmd) begin
            target_a_next   = changed ? tgt_cmd_a : target_a_reg;
            target_b_next   = changed ? tgt_cmd_b : target_b_reg;
            led_next        = changed ? cfg_reg.led_hold : led_reg;
            since_cmd_next  = '0;
            since_step_next = since_step_reg;
        end else begin
            target_a_next   = tgt_tick_a;
            target_b_next   = tgt_tick_b;
            led_next        = (led_reg != '0) ? led_reg - 1'b1 : led_reg;
            since_cmd_next  = since_cmd_inc;
            since_step_next = ctl.step ? '0 : since_step_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_low     <= RST_PWM_LOW;
            cfg_reg.pwm_high    <= RST_PWM_HIGH;
            cfg_reg.step_limit  <= RST_STEP_LIMIT;
            cfg_reg.ramp_period <= RST_RAMP_PERIOD;
            cfg_reg.watchdog    <= RST_WATCHDOG;
            cfg_reg.led_hold    <= RST_LED_HOLD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PWM_LOW:     cfg_reg.pwm_low     <= cfg_wdata[PWM_W-1:0];
                CFG_PWM_HIGH:    cfg_reg.pwm_high    <= cfg_wdata[PWM_W-1:0];
                CFG_STEP_LIMIT:  cfg_reg.step_limit  <= cfg_wdata[PWM_W-1:0];
                CFG_RAMP_PERIOD: cfg_reg.ramp_period <= cfg_wdata[STEP_CNT_W-1:0];
                CFG_WATCHDOG:    cfg_reg.watchdog    <= cfg_wdata[WD_CNT_W-1:0];
                CFG_LED_HOLD:    cfg_reg.led_hold    <= cfg_wdata[LED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg    <= s_tuser;
            in_frac_a_reg <= s_tdata[FRAC_W-1:0];
            in_frac_b_reg <= s_tdata[2*FRAC_W-1:FRAC_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_a_reg   <= RST_STOP;
            target_b_reg   <= RST_STOP;
            drive_a_reg    <= RST_STOP;
            drive_b_reg    <= RST_STOP;
            since_cmd_reg  <= '0;
            since_step_reg <= '0;
            led_reg        <= '0;
        end else if (fire) begin
            target_a_reg   <= target_a_next;
            target_b_reg   <= target_b_next;
            drive_a_reg    <= drive_a_next;
            drive_b_reg    <= drive_b_next;
            since_cmd_reg  <= since_cmd_next;
            since_step_reg <= since_step_next;
            led_reg        <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= M_TDATA_W'({(led_next != '0), pwm_b, pwm_a});
        end
    end

    // a held request stays until it is processed
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("held request lost before processing");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("processed request produced no result");

    a_cmd_clears_wd: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_cmd) |=> (since_cmd_reg == '0))
        else $error("watchdog count not restarted by command");

    a_led_stays_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_cmd && led_reg == '0) |=> (led_reg == '0))
        else $error("sync LED lit by a tick");

endmodule

`default_nettype wire

[verif/pump_duty_checker.sv]
// Result checker for pump_pwm_ramp_with_watchdog: follows the configuration port
// and both stream channels, predicts each result and compares it field by field.
// Depends on ppr_pkg.

module pump_duty_checker import ppr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // pump_a_fraction[16:0], pump_b_fraction[33:17]
    input  logic                  s_tuser,    // cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,    // pwm_a[7:0], pwm_b[15:8], sync_led[16]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [PWM_W-1:0] duty_a;
        logic [PWM_W-1:0] duty_b;
        logic             led_on;
    } duty_t;

    cfg_t                  regs;
    logic [PWM_W-1:0]      goal_a;
    logic [PWM_W-1:0]      goal_b;
    logic [PWM_W-1:0]      drive_a;
    logic [PWM_W-1:0]      drive_b;
    logic [WD_CNT_W-1:0]   idle_ms;
    logic [STEP_CNT_W-1:0] step_ms;
    logic [LED_W-1:0]      led_ms;
    duty_t                 duty_due[$];

    function automatic logic [PWM_W-1:0] stop_duty();
        return PWM_W'((int'(regs.pwm_low) + int'(regs.pwm_high)) >> 1);
    endfunction

    // Q1.16 demand to duty; a reversed range maps downward from pwm_low
    function automatic logic [PWM_W-1:0] frac_to_duty(logic [FRAC_W-1:0] frac_in);
        int frac;
        int lo;
        int hi;
        frac = (frac_in > FRAC_ONE) ? int'(FRAC_ONE) : int'(frac_in);
        lo = int'(regs.pwm_low);
        hi = int'(regs.pwm_high);
        if (hi >= lo) begin
            return PWM_W'(lo + (((hi - lo) * frac) >> 16));
        end
        return PWM_W'(lo - (((lo - hi) * frac) >> 16));
    endfunction

    function automatic logic [PWM_W-1:0] slew(logic [PWM_W-1:0] drive, logic [PWM_W-1:0] goal);
        int span;
        int lim;
        lim = int'(regs.step_limit);
        if (goal >= drive) begin
            span = int'(goal) - int'(drive);
            return PWM_W'(int'(drive) + ((span > lim) ? lim : span));
        end
        span = int'(drive) - int'(goal);
        return PWM_W'(int'(drive) - ((span > lim) ? lim : span));
    endfunction

    // upper bound first, so a reversed range reports pwm_high above it
    function automatic logic [PWM_W-1:0] clamp(logic [PWM_W-1:0] v);
        if (v > regs.pwm_high) return regs.pwm_high;
        if (v < regs.pwm_low) return regs.pwm_low;
        return v;
    endfunction

    function automatic duty_t advance_pumps(logic kind, logic [FRAC_W-1:0] frac_a,
                                            logic [FRAC_W-1:0] frac_b);
        logic [PWM_W-1:0] next_a;
        logic [PWM_W-1:0] next_b;
        duty_t            r;
        if (kind == CMD_SETPOINT) begin
            next_a = frac_to_duty(frac_a);
            next_b = frac_to_duty(frac_b);
            if (next_a != goal_a || next_b != goal_b) begin
                goal_a = next_a;
                goal_b = next_b;
                led_ms = regs.led_hold;
            end
            idle_ms = '0;
        end else begin
            if (led_ms != '0) led_ms = led_ms - 1'b1;
            if (idle_ms != WD_CNT_MAX) idle_ms = idle_ms + 1'b1;
            if (idle_ms >= regs.watchdog) begin
                goal_a  = stop_duty();
                goal_b  = stop_duty();
                drive_a = stop_duty();
                drive_b = stop_duty();
            end
            if (step_ms != STEP_CNT_MAX) step_ms = step_ms + 1'b1;
            if (step_ms >= regs.ramp_period) begin
                drive_a = slew(drive_a, goal_a);
                drive_b = slew(drive_b, goal_b);
                step_ms = '0;
            end
        end
        r.duty_a = clamp(drive_a);
        r.duty_b = clamp(drive_b);
        r.led_on = (led_ms != '0);
        return r;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        duty_t got;
        duty_t want;
        if (!aresetn) begin
            regs.pwm_low     = RST_PWM_LOW;
            regs.pwm_high    = RST_PWM_HIGH;
            regs.step_limit  = RST_STEP_LIMIT;
            regs.ramp_period = RST_RAMP_PERIOD;
            regs.watchdog    = RST_WATCHDOG;
            regs.led_hold    = RST_LED_HOLD;
            goal_a  = RST_STOP;
            goal_b  = RST_STOP;
            drive_a = RST_STOP;
            drive_b = RST_STOP;
            idle_ms = '0;
            step_ms = '0;
            led_ms  = '0;
            duty_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PWM_LOW:     regs.pwm_low     = PWM_W'(cfg_wdata);
                    CFG_PWM_HIGH:    regs.pwm_high    = PWM_W'(cfg_wdata);
                    CFG_STEP_LIMIT:  regs.step_limit  = PWM_W'(cfg_wdata);
                    CFG_RAMP_PERIOD: regs.ramp_period = STEP_CNT_W'(cfg_wdata);
                    CFG_WATCHDOG:    regs.watchdog    = WD_CNT_W'(cfg_wdata);
                    CFG_LED_HOLD:    regs.led_hold    = LED_W'(cfg_wdata);
                    default: ;
                endcase
            end
            // retire results before taking the new request of the same edge
            if (m_tvalid && m_tready) begin
                got.duty_a = m_tdata[PWM_W-1:0];
                got.duty_b = m_tdata[2*PWM_W-1:PWM_W];
                got.led_on = m_tdata[2*PWM_W];
                if (duty_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result %h with nothing expected", $time, m_tdata);
                end else begin
                    want = duty_due.pop_front();
                    check_field("pwm_a", int'(want.duty_a), int'(got.duty_a));
                    check_field("pwm_b", int'(want.duty_b), int'(got.duty_b));
                    check_field("sync_led", int'(want.led_on), int'(got.led_on));
                end
            end
            if (s_tvalid && s_tready) begin
                duty_due.push_back(advance_pumps(s_tuser, s_tdata[FRAC_W-1:0],
                                                 s_tdata[2*FRAC_W-1:FRAC_W]));
            end
        end
        outstanding <= duty_due.size();
    end

endmodule

[verif/testbench.sv]
// Top of the pump PWM ramp testbench: clock, reset, configuration phases and
// request/result traffic with random idling. Depends on ppr_pkg, the block and
// pump_duty_checker, which does all prediction and comparison.

module testbench;
    import ppr_pkg::*;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = CMD_SETPOINT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PWM_LOW;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    mismatches;
    int                    outstanding;
    bit                    quiet;
    bit                    hold_off;
    logic [FRAC_W-1:0]     last_a = '0;
    logic [FRAC_W-1:0]     last_b = '0;

    pump_pwm_ramp_with_watchdog dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    pump_duty_checker duty_watch (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // valid stays high into the next request when no gap is drawn
    task automatic push_request(logic kind, logic [FRAC_W-1:0] frac_a,
                                logic [FRAC_W-1:0] frac_b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({frac_b, frac_a});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
    endtask

    // drain the block completely before touching any register
    task automatic load_regs(int lo, int hi, int slope, int period, int wd, int led);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(CFG_PWM_LOW, lo);
        write_reg(CFG_PWM_HIGH, hi);
        write_reg(CFG_STEP_LIMIT, slope);
        write_reg(CFG_RAMP_PERIOD, period);
        write_reg(CFG_WATCHDOG, wd);
        write_reg(CFG_LED_HOLD, led);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_regs();
        int lo;
        int hi;
        lo = $urandom_range(0, 255);
        hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(lo, 255);
        load_regs(lo, hi,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 90),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 30));
    endtask

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return FRAC_ONE;
            2: return FRAC_W'($urandom_range(0, (1 << FRAC_W) - 1));
            default: return FRAC_W'($urandom_range(0, int'(FRAC_ONE)));
        endcase
    endfunction

    // mostly ticks, with long tick runs to reach the watchdog and ramp steps;
    // setpoints sometimes repeat so the unchanged case shows up
    task automatic run_traffic(int count);
        int left;
        int run;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                run = $urandom_range(1, 60);
                repeat (run) push_request(CMD_TICK, pick_fraction(), pick_fraction());
                left -= run;
            end else if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    last_a = pick_fraction();
                    last_b = pick_fraction();
                end
                push_request(CMD_SETPOINT, last_a, last_b);
                left--;
            end else begin
                push_request(CMD_TICK, pick_fraction(), pick_fraction());
                left--;
            end
        end
    endtask

    initial begin : drain
        int gap;
        wait (aresetn);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 17);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: full-scale demands, saturation, repeated setpoint
        push_request(CMD_SETPOINT, '0, FRAC_ONE);
        repeat (3) push_request(CMD_TICK, '1, '0);
        push_request(CMD_SETPOINT, '1, '0);
        push_request(CMD_SETPOINT, '1, '0);
        push_request(CMD_SETPOINT, FRAC_W'(1), FRAC_W'(65535));
        push_request(CMD_TICK, '0, '1);
        push_request(CMD_SETPOINT, FRAC_ONE, FRAC_ONE);

        // reversed range, zero period, zero timeout, LED never lit
        load_regs(200, 40, 255, 0, 0, 0);
        push_request(CMD_SETPOINT, '0, FRAC_ONE);
        push_request(CMD_TICK, '0, '0);
        push_request(CMD_SETPOINT, FRAC_W'(32768), '1);
        repeat (2) push_request(CMD_TICK, '1, '1);

        // short timeout and LED hold that run out within a few ticks
        load_regs(0, 255, 1, 1, 3, 2);
        push_request(CMD_SETPOINT, FRAC_ONE, '0);
        repeat (4) push_request(CMD_TICK, '0, '0);
        push_request(CMD_SETPOINT, '0, '0);
        push_request(CMD_TICK, '0, '0);

        for (phase = 0; phase < 12; phase++) begin
            case (phase)
                0: load_regs(0, 255, 255, 1023, 8191, 2047);
                1: load_regs(0, 0, 0, 0, 0, 0);
                2: load_regs(255, 0, 7, 2, 20, 9);
                default: random_regs();
            endcase
            quiet = (phase % 3 == 2);
            // stall the result side long enough to back up the input
            if (phase == 5) begin
                quiet    = 1'b1;
                hold_off = 1'b1;
            end
            run_traffic(170);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ppr_pkg.sv
rtl/ppr_chan.sv
rtl/pump_pwm_ramp_with_watchdog.sv
verif/pump_duty_checker.sv
verif/testbench.sv
